@@ rtl/lru_key_value_cache_assert.svh @@
// Assertion macros for the LRU key-value cache.
// Expects clk and arst_n in the scope of each use.
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LKVC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define LKVC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/lkvc_pkg.sv @@
// Shared constants and types for the LRU key-value cache.
// No dependencies.
package lkvc_pkg;

	localparam int KEY_W     = 16;
	localparam int VAL_W     = 31;
	localparam int CAP_W     = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic ACT_GET = 1'b0;
	localparam logic ACT_PUT = 1'b1;

	typedef struct packed {
		logic             action;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} item_t;

endpackage

@@ rtl/lru_key_value_cache.sv @@
// Fully associative key-value cache with LRU replacement (per-entry rank).
// Depends on lkvc_pkg and lru_key_value_cache_assert.svh.
//
//  channel | handshake         | payload
//  --------+-------------------+------------------------------------
//  request | start / busy      | action, lookup_key, put_value
//  result  | done (one cycle)  | found, read_value
//  config  | cfg_wr_en         | cfg_wr_data (capacity_in_use)
//
// One beat accepted per cycle; busy is held low.
// A get result passes through the request register and then the result register
// before it reaches the outputs; a put gives no result.
// Lookup and rank update are one compare pass
// over all entries between the request register and the state/result registers.
// Reset clears valid marks, ranks, fill count; capacity resets to 16.
// The receiver cannot stall: done is a single-cycle strobe.
module lru_key_value_cache #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        action,
	input  logic [lkvc_pkg::KEY_W-1:0]  lookup_key,
	input  logic [lkvc_pkg::VAL_W-1:0]  put_value,
	output logic                        done,
	output logic                        found,
	output logic [lkvc_pkg::VAL_W-1:0]  read_value,
	input  logic                        cfg_wr_en,
	input  logic [lkvc_pkg::CAP_W-1:0]  cfg_wr_data
);

`include "lru_key_value_cache_assert.svh"

	localparam int RANK_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W  = (CNT_W > lkvc_pkg::CAP_W) ? CNT_W : lkvc_pkg::CAP_W;

	logic                         vld_s1;
	lkvc_pkg::item_t              item_s1;
	logic [lkvc_pkg::CAP_W-1:0]   cap_q;
	logic [MAX_ENTRIES-1:0]       valid_q;
	logic [lkvc_pkg::KEY_W-1:0]   key_q   [MAX_ENTRIES];
	logic [lkvc_pkg::VAL_W-1:0]   value_q [MAX_ENTRIES];
	logic [RANK_W-1:0]            rank_q  [MAX_ENTRIES];
	logic [CNT_W-1:0]             fill_q;
	logic                         done_q;
	logic                         found_q;
	logic [lkvc_pkg::VAL_W-1:0]   rdval_q;

	logic [MAX_ENTRIES-1:0]       hit_vec;
	logic                         hit_any;
	logic [RANK_W-1:0]            hit_rank;
	logic [lkvc_pkg::VAL_W-1:0]   hit_value;
	logic [CMP_W-1:0]             cap_ext;
	logic [CMP_W-1:0]             cap_eff;
	logic [CNT_W-1:0]             n1;
	logic [CNT_W-1:0]             n2;
	logic                         evict;
	logic [RANK_W-1:0]            last_rank;
	logic [MAX_ENTRIES-1:0]       valid1;
	logic [MAX_ENTRIES-1:0]       victim;
	logic [MAX_ENTRIES-1:0]       valid2;
	logic [MAX_ENTRIES-1:0]       free_vec;
	logic [MAX_ENTRIES-1:0]       free_oh;
	logic [RANK_W-1:0]            rank1   [MAX_ENTRIES];
	logic                         accept;
	logic                         is_put;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign is_put = (item_s1.action == lkvc_pkg::ACT_PUT);

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.action <= action;
			item_s1.key    <= lookup_key;
			item_s1.value  <= put_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lkvc_pkg::CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	// lookup
	always_comb begin
		hit_rank  = '0;
		hit_value = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			hit_vec[i] = valid_q[i] && (key_q[i] == item_s1.key);
			hit_rank   = hit_rank  | (hit_vec[i] ? rank_q[i]  : '0);
			hit_value  = hit_value | (hit_vec[i] ? value_q[i] : '0);
		end
		hit_any = |hit_vec;
	end

	// effective capacity clamped to 1..MAX_ENTRIES
	always_comb begin
		cap_ext = CMP_W'(cap_q);
		priority if (cap_ext == '0) begin
			cap_eff = CMP_W'(1);
		end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
			cap_eff = CMP_W'(MAX_ENTRIES);
		end else begin
			cap_eff = cap_ext;
		end
	end

	// put: drop same key, evict LRU if full, insert at lowest free slot
	always_comb begin
		n1        = fill_q - CNT_W'(hit_any);
		evict     = CMP_W'(n1) >= cap_eff;
		last_rank = RANK_W'(n1 - CNT_W'(1));
		valid1    = valid_q & ~hit_vec;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			rank1[i]  = rank_q[i] - RANK_W'(hit_any && (rank_q[i] > hit_rank));
			victim[i] = evict && valid1[i] && (rank1[i] == last_rank);
		end
		valid2   = valid1 & ~victim;
		n2       = n1 - CNT_W'(evict);
		free_vec = ~valid2;
		free_oh  = free_vec & (~free_vec + MAX_ENTRIES'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			fill_q  <= '0;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (vld_s1) begin
			if (is_put) begin
				valid_q <= valid2 | free_oh;
				fill_q  <= n2 + CNT_W'(1);
				for (int i = 0; i < MAX_ENTRIES; i++) begin
					if (free_oh[i]) begin
						rank_q[i] <= '0;
					end else if (valid2[i]) begin
						rank_q[i] <= rank1[i] + RANK_W'(1);
					end
				end
			end else if (hit_any) begin
				for (int i = 0; i < MAX_ENTRIES; i++) begin
					if (hit_vec[i]) begin
						rank_q[i] <= '0;
					end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
						rank_q[i] <= rank_q[i] + RANK_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (vld_s1 && is_put && free_oh[i]) begin
				key_q[i]   <= item_s1.key;
				value_q[i] <= item_s1.value;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s1 && !is_put;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && !is_put) begin
			found_q <= hit_any;
			rdval_q <= hit_value;
		end
	end

	assign done       = done_q;
	assign found      = found_q;
	assign read_value = rdval_q;

	`LKVC_ASSERT_NOW(a_fill_matches_valid, 1'b1, $countones(valid_q) == fill_q,
		"fill count out of step with valid marks")
	`LKVC_ASSERT_NOW(a_hit_unique, vld_s1, $onehot0(hit_vec),
		"key present in more than one entry")
	`LKVC_ASSERT_NEXT(a_get_gives_result, vld_s1 && !is_put, done,
		"get beat produced no result")
	`LKVC_ASSERT_NEXT(a_put_inserts, vld_s1 && is_put, !done && (fill_q != '0),
		"put beat left cache empty or produced a result")
	`LKVC_ASSERT_NOW(a_miss_reads_zero, done && !found, read_value == '0,
		"miss returned nonzero value")

endmodule

@@ test/lru_key_value_cache_tb.sv @@
// Testbench for lru_key_value_cache: directed and random get/put beats against
// an in-bench LRU predictor, with capacity changes between phases.
// Depends on lkvc_pkg and the lru_key_value_cache RTL.
`timescale 1ns / 1ps

module lru_key_value_cache_tb;

	localparam int DEPTH = 16;

	typedef struct {
		logic                       hit;
		logic [lkvc_pkg::VAL_W-1:0] data;
	} read_result_t;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	logic                       action;
	logic [lkvc_pkg::KEY_W-1:0] lookup_key;
	logic [lkvc_pkg::VAL_W-1:0] put_value;
	logic                       done;
	logic                       found;
	logic [lkvc_pkg::VAL_W-1:0] read_value;
	logic                       cfg_wr_en;
	logic [lkvc_pkg::CAP_W-1:0] cfg_wr_data;

	// predictor state
	logic                       slot_valid [DEPTH];
	logic [lkvc_pkg::KEY_W-1:0] slot_key   [DEPTH];
	logic [lkvc_pkg::VAL_W-1:0] slot_data  [DEPTH];
	logic [3:0]                 slot_rank  [DEPTH];
	logic [lkvc_pkg::CAP_W-1:0] capacity_reg;

	read_result_t               pending_reads[$];
	int                         mismatches;
	bit                         idle_on;
	logic [lkvc_pkg::KEY_W-1:0] key_base;

	lru_key_value_cache #(
		.MAX_ENTRIES(DEPTH)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.lookup_key (lookup_key),
		.put_value  (put_value),
		.done       (done),
		.found      (found),
		.read_value (read_value),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #1 clk = ~clk;

	initial begin
		#200000;
		$display("[lru_key_value_cache] ERROR");
		$finish;
	end

	function automatic void drop_slot(int s);
		logic [3:0] r;
		r = slot_rank[s];
		slot_valid[s] = 1'b0;
		for (int i = 0; i < DEPTH; i++)
			if (slot_valid[i] && slot_rank[i] > r)
				slot_rank[i] = slot_rank[i] - 1'b1;
	endfunction

	function automatic void apply_request(logic act, logic [lkvc_pkg::KEY_W-1:0] key,
			logic [lkvc_pkg::VAL_W-1:0] val);
		int           s;
		int           n;
		int           cap;
		int           free_slot;
		logic [3:0]   r;
		read_result_t res;
		s = -1;
		for (int i = 0; i < DEPTH; i++)
			if (s < 0 && slot_valid[i] && slot_key[i] == key)
				s = i;
		if (act == lkvc_pkg::ACT_GET) begin
			res.hit = (s >= 0);
			res.data = '0;
			if (s >= 0) begin
				res.data = slot_data[s];
				r = slot_rank[s];
				for (int i = 0; i < DEPTH; i++)
					if (slot_valid[i] && slot_rank[i] < r)
						slot_rank[i] = slot_rank[i] + 1'b1;
				slot_rank[s] = '0;
			end
			pending_reads.push_back(res);
			return;
		end
		cap = int'(capacity_reg);
		if (cap < 1)
			cap = 1;
		if (cap > DEPTH)
			cap = DEPTH;
		if (s >= 0)
			drop_slot(s);
		n = 0;
		for (int i = 0; i < DEPTH; i++)
			if (slot_valid[i])
				n++;
		if (n >= cap && n > 0) begin
			s = -1;
			for (int i = 0; i < DEPTH; i++)
				if (s < 0 && slot_valid[i] && int'(slot_rank[i]) == n - 1)
					s = i;
			if (s >= 0)
				drop_slot(s);
		end
		free_slot = -1;
		for (int i = 0; i < DEPTH; i++)
			if (free_slot < 0 && !slot_valid[i])
				free_slot = i;
		if (free_slot >= 0) begin
			for (int i = 0; i < DEPTH; i++)
				if (slot_valid[i])
					slot_rank[i] = slot_rank[i] + 1'b1;
			slot_valid[free_slot] = 1'b1;
			slot_key[free_slot] = key;
			slot_data[free_slot] = val;
			slot_rank[free_slot] = '0;
		end
	endfunction

	task automatic send_beat(input logic act, input logic [lkvc_pkg::KEY_W-1:0] key,
			input logic [lkvc_pkg::VAL_W-1:0] val);
		while (idle_on && $urandom_range(99) < 36) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		action <= act;
		lookup_key <= key;
		put_value <= val;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		apply_request(act, key, val);
	endtask

	task automatic wait_results_settled();
		start <= 1'b0;
		while (pending_reads.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [lkvc_pkg::CAP_W-1:0] cap);
		wait_results_settled();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= cap;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		capacity_reg = cap;
	endtask

	function automatic logic [lkvc_pkg::KEY_W-1:0] pick_key(int span);
		int r;
		r = $urandom_range(99);
		if (r < 85)
			return key_base + lkvc_pkg::KEY_W'($urandom_range(span));
		if (r < 93)
			return lkvc_pkg::KEY_W'($urandom);
		return (r < 96) ? '0 : '1;
	endfunction

	function automatic logic [lkvc_pkg::VAL_W-1:0] pick_value();
		int r;
		r = $urandom_range(99);
		if (r < 3)
			return '0;
		if (r < 6)
			return '1;
		return lkvc_pkg::VAL_W'($urandom);
	endfunction

	// result checker
	always @(posedge clk) begin
		read_result_t exp_res;
		if (arst_n && done) begin
			if (pending_reads.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: found=%0b value=%h", found, read_value);
			end else begin
				exp_res = pending_reads.pop_front();
				if (found !== exp_res.hit) begin
					mismatches++;
					if (mismatches <= 10)
						$display("found mismatch: exp %0b got %0b", exp_res.hit, found);
				end
				if (read_value !== exp_res.data) begin
					mismatches++;
					if (mismatches <= 10)
						$display("read_value mismatch: exp %h got %h",
							exp_res.data, read_value);
				end
			end
		end
	end

	task automatic test_empty_and_extremes();
		send_beat(lkvc_pkg::ACT_GET, '0, '1);
		send_beat(lkvc_pkg::ACT_PUT, '0, '0);
		send_beat(lkvc_pkg::ACT_GET, '0, '1);
		send_beat(lkvc_pkg::ACT_PUT, '1, '1);
		send_beat(lkvc_pkg::ACT_GET, '1, '0);
		send_beat(lkvc_pkg::ACT_GET, 16'h1234, 31'h2AAA_5555);
	endtask

	task automatic test_key_update();
		send_beat(lkvc_pkg::ACT_PUT, '0, '1);
		send_beat(lkvc_pkg::ACT_GET, '0, '0);
		send_beat(lkvc_pkg::ACT_PUT, '1, 31'h5555_AAAA);
		send_beat(lkvc_pkg::ACT_GET, '1, '0);
	endtask

	// capacity 1 with two entries held: fill stays above capacity until a held key is put again
	task automatic test_small_capacity();
		write_capacity(5'd1);
		send_beat(lkvc_pkg::ACT_PUT, 16'd10, 31'd1);
		send_beat(lkvc_pkg::ACT_PUT, 16'd11, 31'd2);
		send_beat(lkvc_pkg::ACT_GET, 16'd10, '0);
		send_beat(lkvc_pkg::ACT_GET, 16'd11, '0);
		send_beat(lkvc_pkg::ACT_PUT, 16'd11, 31'd3);
		send_beat(lkvc_pkg::ACT_GET, 16'd11, '0);
		send_beat(lkvc_pkg::ACT_GET, '1, '0);
	endtask

	task automatic test_capacity_clamp();
		write_capacity(5'd0);
		send_beat(lkvc_pkg::ACT_PUT, 16'd20, 31'd20);
		send_beat(lkvc_pkg::ACT_GET, 16'd20, '0);
		send_beat(lkvc_pkg::ACT_GET, 16'd11, '0);
		write_capacity(5'd31);
		for (int i = 0; i < 3; i++)
			send_beat(lkvc_pkg::ACT_PUT, lkvc_pkg::KEY_W'(16'd30 + i),
				lkvc_pkg::VAL_W'(i));
		send_beat(lkvc_pkg::ACT_GET, 16'd30, '0);
		send_beat(lkvc_pkg::ACT_GET, 16'd20, '0);
	endtask

	task automatic test_random_phase(input logic [lkvc_pkg::CAP_W-1:0] cap,
			input int beats, input bit with_idle);
		int span;
		write_capacity(cap);
		idle_on = with_idle;
		span = (cap == 0) ? 3 : int'(cap) + $urandom_range(2, 8);
		key_base = lkvc_pkg::KEY_W'($urandom_range(65535 - span));
		for (int i = 0; i < beats; i++)
			send_beat($urandom_range(1) ? lkvc_pkg::ACT_PUT : lkvc_pkg::ACT_GET,
				pick_key(span), pick_value());
	endtask

	initial begin
		mismatches = 0;
		idle_on = 1'b0;
		capacity_reg = lkvc_pkg::CAP_RESET;
		for (int i = 0; i < DEPTH; i++) begin
			slot_valid[i] = 1'b0;
			slot_key[i] = '0;
			slot_data[i] = '0;
			slot_rank[i] = '0;
		end
		arst_n <= 1'b0;
		start <= 1'b0;
		action <= lkvc_pkg::ACT_GET;
		lookup_key <= '0;
		put_value <= '0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_and_extremes();
		test_key_update();
		test_small_capacity();
		test_capacity_clamp();

		test_random_phase(5'd16, 250, 1'b1);
		test_random_phase(5'd4, 200, 1'b1);
		test_random_phase(5'd1, 150, 1'b1);
		test_random_phase(5'd16, 300, 1'b0);
		test_random_phase(5'd0, 120, 1'b1);
		test_random_phase(5'd31, 250, 1'b1);
		test_random_phase(5'd8, 200, 1'b1);
		test_random_phase(5'd2, 150, 1'b1);
		test_random_phase(5'd13, 130, 1'b1);

		wait_results_settled();
		repeat (8) @(posedge clk);
		if (pending_reads.size() != 0)
			mismatches++;
		if (mismatches == 0) begin
			$display("[lru_key_value_cache] OK");
		end else begin
			$display("[lru_key_value_cache] ERROR");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/lkvc_pkg.sv
rtl/lru_key_value_cache.sv
test/lru_key_value_cache_tb.sv
